[hw/rtl/oale_pkg.sv]
// Shared types and constants for the ordered array list engine.
package oale_pkg;

  localparam int REQ_W     = 2;
  localparam int POS_W     = 7;
  localparam int CAT_W     = 3;
  localparam int NTH_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int IDX_OUT_W = 6;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_DELETE   = 2'd1,
    REQ_FIND_KEY = 2'd2,
    REQ_FIND_NTH = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // where the entry fields of a result come from
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_REQ  = 2'd1,
    SRC_HIT  = 2'd2
  } src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INS_WALK,
    S_INS_PUT,
    S_DEL_WALK,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    init_walk;
    logic    ins_walk;
    logic    del_walk;
    logic    srch_walk;
    logic    put_new;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    status_t out_status;
    src_t    out_src;
  } dp_cmd_t;

  typedef struct packed {
    req_t op;
    logic full;
    logic ins_bad;
    logic del_bad;
    logic ins_done;
    logic del_done;
    logic srch_done;
    logic found;
    logic out_free;
  } dp_stat_t;

endpackage

[hw/rtl/oale_ctrl.sv]
// Request sequencer: decodes the request and steps the datapath through its walk.
module oale_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  oale_pkg::dp_stat_t stat,
  output oale_pkg::dp_cmd_t  cmd
);
  import oale_pkg::*;

  state_t  state, state_next;
  status_t fin_status, fin_status_next;
  src_t    fin_src, fin_src_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    fin_status <= fin_status_next;
    fin_src    <= fin_src_next;
  end

  always_comb begin
    state_next      = state;
    fin_status_next = fin_status;
    fin_src_next    = fin_src;
    in_stall        = 1'b1;
    cmd             = '0;
    cmd.out_status  = fin_status;
    cmd.out_src     = fin_src;
    unique case (state)
      S_IDLE: begin
        // no transfer is taken while reset is applied
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.init_walk = 1'b1;
        unique case (stat.op)
          REQ_INSERT: begin
            // full is checked before the position
            priority if (stat.full) begin
              fin_status_next = ST_FULL;
              fin_src_next    = SRC_NONE;
              state_next      = S_DONE;
            end else if (stat.ins_bad) begin
              fin_status_next = ST_BAD_POS;
              fin_src_next    = SRC_NONE;
              state_next      = S_DONE;
            end else begin
              state_next = S_INS_WALK;
            end
          end
          REQ_DELETE: begin
            if (stat.del_bad) begin
              fin_status_next = ST_BAD_POS;
              fin_src_next    = SRC_NONE;
              state_next      = S_DONE;
            end else begin
              state_next = S_DEL_WALK;
            end
          end
          REQ_FIND_KEY, REQ_FIND_NTH: begin
            state_next = S_SEARCH;
          end
          default: begin
            state_next = S_SEARCH;
          end
        endcase
      end
      S_INS_WALK: begin
        cmd.ins_walk = 1'b1;
        if (stat.ins_done) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd.put_new     = 1'b1;
        cmd.cnt_inc     = 1'b1;
        fin_status_next = ST_OK;
        fin_src_next    = SRC_REQ;
        state_next      = S_DONE;
      end
      S_DEL_WALK: begin
        cmd.del_walk = 1'b1;
        if (stat.del_done) begin
          cmd.cnt_dec     = 1'b1;
          fin_status_next = ST_OK;
          fin_src_next    = SRC_HIT;
          state_next      = S_DONE;
        end
      end
      S_SEARCH: begin
        cmd.srch_walk = 1'b1;
        if (stat.srch_done) begin
          fin_status_next = stat.found ? ST_OK : ST_NOT_FOUND;
          fin_src_next    = stat.found ? SRC_HIT : SRC_NONE;
          state_next      = S_DONE;
        end
      end
      S_DONE: begin
        // wait here until the output register can take the result
        cmd.out_load = stat.out_free;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/oale_dp.sv]
// List datapath: entry memory, count, walk pointer, match logic and result register.
module oale_dp #(
  parameter int CAPACITY     = 64,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [oale_pkg::REQ_W-1:0]    req_type,
  input  logic [oale_pkg::POS_W-1:0]    position,
  input  logic [KEY_BITS-1:0]           entry_key,
  input  logic [oale_pkg::CAT_W-1:0]    entry_category,
  input  logic [PAYLOAD_BITS-1:0]       entry_payload,
  input  logic [oale_pkg::NTH_W-1:0]    nth_match,
  input  oale_pkg::dp_cmd_t             cmd,
  output oale_pkg::dp_stat_t            stat,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [oale_pkg::STATUS_W-1:0] status,
  output logic [oale_pkg::IDX_OUT_W-1:0] found_index,
  output logic [KEY_BITS-1:0]           out_key,
  output logic [oale_pkg::CAT_W-1:0]    out_category,
  output logic [PAYLOAD_BITS-1:0]       out_payload,
  output logic [oale_pkg::CNT_OUT_W-1:0] entry_count
);
  import oale_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int PN_W   = (POS_W > NTH_W) ? POS_W : NTH_W;
  localparam int CMP_W  = (CNT_W > PN_W) ? CNT_W : PN_W;
  localparam int FI_W   = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
  localparam int EC_W   = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam int ENT_W  = KEY_BITS + CAT_W + PAYLOAD_BITS;

  // entry layout: {key, category, payload}
  logic [ENT_W-1:0] mem [CAPACITY];

  req_t              req_op;
  logic [POS_W-1:0]  req_pos;
  logic [KEY_BITS-1:0] req_key;
  logic [CAT_W-1:0]  req_cat;
  logic [PAYLOAD_BITS-1:0] req_pay;
  logic [NTH_W-1:0]  req_nth;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  seen;
  logic [ENT_W-1:0]  rd_data;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_live;
  logic              found;
  logic [ENT_W-1:0]  hit_entry;
  logic [IDX_W-1:0]  hit_idx;

  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  count_w;
  logic [CNT_W-1:0]  pos_c;
  logic [CNT_W-1:0]  ptr_m1;
  logic [CNT_W-1:0]  seen_inc;
  logic              ins_rd, del_rd, srch_rd, rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              key_hit, cat_hit, nth_hit, match, cat_step, del_take;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic [ENT_W-1:0]  req_entry;
  logic              out_free;
  logic [IDX_W-1:0]  ld_idx;
  logic [ENT_W-1:0]  ld_ent;
  logic [FI_W-1:0]   ld_idx_w;
  logic [EC_W-1:0]   count_ext;

  assign req_entry = {req_key, req_cat, req_pay};
  assign pos_w     = CMP_W'(req_pos);
  assign count_w   = CMP_W'(count);
  assign pos_c     = pos_w[CNT_W-1:0];
  assign ptr_m1    = ptr - CNT_W'(1);
  assign seen_inc  = seen + CNT_W'(1);

  // walk reads: insert walks down from the end, delete and search walk up
  assign ins_rd  = cmd.ins_walk && (ptr > pos_c);
  assign del_rd  = cmd.del_walk && (ptr < count);
  assign srch_rd = cmd.srch_walk && (ptr < count) && !found;
  assign rd_en   = ins_rd || del_rd || srch_rd;
  assign rd_addr = ins_rd ? ptr_m1[IDX_W-1:0] : ptr[IDX_W-1:0];

  assign key_hit  = rd_data[ENT_W-1 -: KEY_BITS] == req_key;
  assign cat_hit  = rd_data[PAYLOAD_BITS +: CAT_W] == req_cat;
  assign nth_hit  = cat_hit && (CMP_W'(seen_inc) == CMP_W'(req_nth));
  assign cat_step = cmd.srch_walk && rd_live && !found && (req_op == REQ_FIND_NTH) && cat_hit;
  assign match    = cmd.srch_walk && rd_live && !found &&
                    ((req_op == REQ_FIND_KEY) ? key_hit : nth_hit);
  // first read of a delete walk is the removed entry itself
  assign del_take = cmd.del_walk && rd_live && (rd_idx == pos_c[IDX_W-1:0]);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = rd_data;
    priority if (cmd.put_new) begin
      wr_en   = 1'b1;
      wr_addr = pos_c[IDX_W-1:0];
      wr_data = req_entry;
    end else if (cmd.ins_walk && rd_live) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx + IDX_W'(1);
    end else if (cmd.del_walk && rd_live && !del_take) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx - IDX_W'(1);
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_live   <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_live <= rd_en;
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.init_walk) begin
        found <= 1'b0;
      end else if (match) begin
        found <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op  <= req_t'(req_type);
      req_pos <= position;
      req_key <= entry_key;
      req_cat <= entry_category;
      req_pay <= entry_payload;
      req_nth <= nth_match;
    end
    if (cmd.init_walk) begin
      unique case (req_op)
        REQ_INSERT: ptr <= count;
        REQ_DELETE: ptr <= pos_c;
        default:    ptr <= '0;
      endcase
      seen <= '0;
    end else begin
      if (rd_en) begin
        ptr <= ins_rd ? ptr_m1 : (ptr + CNT_W'(1));
      end
      if (cat_step) begin
        seen <= seen_inc;
      end
    end
    if (rd_en) begin
      rd_idx <= rd_addr;
    end
    if (match || del_take) begin
      hit_entry <= rd_data;
      hit_idx   <= rd_idx;
    end
  end

  // result register
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (cmd.out_src)
      SRC_REQ: begin
        ld_idx = pos_c[IDX_W-1:0];
        ld_ent = req_entry;
      end
      SRC_HIT: begin
        ld_idx = hit_idx;
        ld_ent = hit_entry;
      end
      default: begin
        ld_idx = '0;
        ld_ent = '0;
      end
    endcase
  end

  assign ld_idx_w  = FI_W'(ld_idx);
  assign count_ext = EC_W'(count);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= cmd.out_status;
      found_index  <= ld_idx_w[IDX_OUT_W-1:0];
      out_key      <= ld_ent[ENT_W-1 -: KEY_BITS];
      out_category <= ld_ent[PAYLOAD_BITS +: CAT_W];
      out_payload  <= ld_ent[PAYLOAD_BITS-1:0];
      entry_count  <= count_ext[CNT_OUT_W-1:0];
    end
  end

  assign stat.op        = req_op;
  assign stat.full      = count == CNT_W'(CAPACITY);
  assign stat.ins_bad   = pos_w > count_w;
  assign stat.del_bad   = pos_w >= count_w;
  assign stat.ins_done  = (ptr == pos_c) && !rd_live;
  assign stat.del_done  = (ptr == count) && !rd_live;
  assign stat.srch_done = found || ((ptr == count) && !rd_live);
  assign stat.found     = found;
  assign stat.out_free  = out_free;

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded over an untaken result");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> CNT_W'(wr_addr) <= count)
    else $error("write beyond the live end of the list");

  a_inc_one: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list by one");

endmodule

[hw/rtl/ordered_array_list_engine.sv]
// Ordered array list engine top level: sequencer plus list datapath.
//
// Holds a dense ordered list of up to CAPACITY entries in a single-port-write,
// single-port-read memory and serves one request at a time: insert at a
// position, delete at a position, find first by key, find nth of a category.
// Each request gives exactly one result. A request walks the memory one entry
// per cycle; the entries walked are count minus position for a delete or an
// insert, and those up to and including the match (or all count entries on a
// miss) for a search. The next request is taken once the previous result is in
// the output register, even if that result is still stalled. The memory needs
// no clearing after reset.
module ordered_array_list_engine #(
  parameter int CAPACITY     = 64,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [oale_pkg::REQ_W-1:0]     req_type,
  input  logic [oale_pkg::POS_W-1:0]     position,
  input  logic [KEY_BITS-1:0]            entry_key,
  input  logic [oale_pkg::CAT_W-1:0]     entry_category,
  input  logic [PAYLOAD_BITS-1:0]        entry_payload,
  input  logic [oale_pkg::NTH_W-1:0]     nth_match,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [oale_pkg::STATUS_W-1:0]  status,
  output logic [oale_pkg::IDX_OUT_W-1:0] found_index,
  output logic [KEY_BITS-1:0]            out_key,
  output logic [oale_pkg::CAT_W-1:0]     out_category,
  output logic [PAYLOAD_BITS-1:0]        out_payload,
  output logic [oale_pkg::CNT_OUT_W-1:0] entry_count
);
  import oale_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  oale_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  oale_dp #(
    .CAPACITY     (CAPACITY),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_type       (req_type),
    .position       (position),
    .entry_key      (entry_key),
    .entry_category (entry_category),
    .entry_payload  (entry_payload),
    .nth_match      (nth_match),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .found_index    (found_index),
    .out_key        (out_key),
    .out_category   (out_category),
    .out_payload    (out_payload),
    .entry_count    (entry_count)
  );

endmodule
